### hw/rtl/gbbd_pkg.sv
package gbbd_pkg;

   // Frame geometry
   localparam int MAX_OUT_HEIGHT = 1024;
   localparam int MAX_OUT_WIDTH  = 4096;
   localparam int ROW_W     = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
   localparam int COL_W     = 12;
   localparam int OUT_ROW_W = 10;

   // Pixel and arithmetic widths
   localparam int NUM_CHAN  = 3;
   localparam int CHAN_W    = 8;
   localparam int CONTRIB_W = 10;   // up to three filtered values
   localparam int SUM_W     = 12;   // 3x3 block sum, wraps like the accumulator
   localparam int ACC_W     = 21;   // 5-tap Q0.12 product sum
   localparam int FRAC_W    = 12;

   // Kernel 0.1201 / 0.2339 / 0.2931 in Q0.12
   localparam logic [ACC_W-1:0] TAP_OUTER  = ACC_W'(492);
   localparam logic [ACC_W-1:0] TAP_INNER  = ACC_W'(958);
   localparam logic [ACC_W-1:0] TAP_CENTER = ACC_W'(1201);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);

   // (s + 4) / 9 as multiply by ceil(2^16 / 9), exact below 32768
   localparam int AVG_N_W     = SUM_W + 1;
   localparam int AVG_P_W     = 2 * AVG_N_W;
   localparam int RECIP_SHIFT = 16;
   localparam logic [AVG_P_W-1:0] RECIP_NINE = AVG_P_W'(7282);
   localparam logic [AVG_N_W-1:0] AVG_BIAS   = AVG_N_W'(4);

   // Stream widths
   localparam int REQ_DATA_W    = NUM_CHAN * CHAN_W;
   localparam int RSP_FIELDS_W  = NUM_CHAN * CHAN_W + COL_W + OUT_ROW_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register port
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int WIDTH_REG_W    = 13;
   localparam int HEIGHT_REG_W   = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [COL_W-1:0] RESET_WIDTH_M1  = COL_W'(299);
   localparam logic [ROW_W-1:0] RESET_HEIGHT_M1 = ROW_W'(299);

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CREDIT_W   = FIFO_CNT_W + 1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] pixel_type;              // [0] red, [1] green, [2] blue
   typedef logic [NUM_CHAN-1:0][CONTRIB_W-1:0] contrib_type;
   typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sum_type;
   typedef logic [1:0] phase_type;
   typedef logic [1:0] warm_type;

   // Position inside a 3-group
   localparam phase_type PH_FIRST = 2'd0;
   localparam phase_type PH_MID   = 2'd1;
   localparam phase_type PH_LAST  = 2'd2;

   // Column start-up: rows 0 and 1 only fill the window
   localparam warm_type WARM_ROW0 = 2'd0;
   localparam warm_type WARM_ROW1 = 2'd1;
   localparam warm_type WARM_RUN  = 2'd2;

   typedef struct packed {
      logic             do_filter;   // one row leaves the filter
      logic             last_step;   // bottom sample: three rows leave the filter
      logic             emit;        // completes a 3x3 block
      phase_type        row_ph;
      logic [ROW_W-1:0] row;
      phase_type        col_ph;
      logic [COL_W-1:0] col;
   } ctl_type;

   function automatic phase_type phase_next(input phase_type p);
      phase_type r;
      r = (p == PH_LAST) ? PH_FIRST : phase_type'(p + 2'd1);
      return r;
   endfunction

   function automatic chan_type filter_chan(input chan_type a, input chan_type b,
                                            input chan_type c, input chan_type d,
                                            input chan_type e);
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] rnd;
      acc = (ACC_W'(a) + ACC_W'(e)) * TAP_OUTER
          + (ACC_W'(b) + ACC_W'(d)) * TAP_INNER
          + ACC_W'(c) * TAP_CENTER;
      rnd = acc + ROUND_HALF;
      if (|rnd[ACC_W-1:FRAC_W+CHAN_W]) return '1;
      return rnd[FRAC_W+CHAN_W-1:FRAC_W];
   endfunction

   function automatic pixel_type filter_pixel(input pixel_type a, input pixel_type b,
                                              input pixel_type c, input pixel_type d,
                                              input pixel_type e);
      pixel_type r;
      for (int k = 0; k < NUM_CHAN; k++) begin
         r[k] = filter_chan(a[k], b[k], c[k], d[k], e[k]);
      end
      return r;
   endfunction

   function automatic chan_type avg9(input logic [SUM_W-1:0] s);
      logic [AVG_N_W-1:0] n;
      logic [AVG_P_W-1:0] p;
      n = AVG_N_W'(s) + AVG_BIAS;
      p = AVG_P_W'(n) * RECIP_NINE;
      if (|p[AVG_P_W-1:RECIP_SHIFT+CHAN_W]) return '1;
      return p[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
   endfunction

   function automatic logic [COL_W-1:0] eff_width_m1(input logic [WIDTH_REG_W-1:0] w);
      logic [COL_W-1:0] r;
      if (w == '0) r = '0;
      else if (32'(w) > MAX_OUT_WIDTH) r = COL_W'(MAX_OUT_WIDTH - 1);
      else r = COL_W'(w - WIDTH_REG_W'(1));
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] eff_height_m1(input logic [HEIGHT_REG_W-1:0] h);
      logic [ROW_W-1:0] r;
      if (h == '0) r = '0;
      else if (32'(h) > MAX_OUT_HEIGHT) r = ROW_W'(MAX_OUT_HEIGHT - 1);
      else r = ROW_W'(h - HEIGHT_REG_W'(1));
      return r;
   endfunction

endpackage

### hw/rtl/gbbd_ram.sv
module gbbd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/gaussian_blur_box_downsample.sv
// Vertical 5-tap Gaussian blur plus 3x3 box downsample for 3x supersampled RGB.
//
// req_*: one supersampled pixel per request, column-major, each column
//   3*out_height samples tall, 3*out_width columns per frame.
// rsp_*: one averaged output pixel with its column and row, sent when the
//   request that finishes its 3x3 block has gone through the pipeline.
// csr_*: index 0 out_width, index 1 out_height; a write to either restarts
//   the frame. Write only while the block is idle. csr_ready is always high.
//
// Throughput: one request per clock while req_tready is high. A request that
// completes a block passes the input register, filter register, accumulate
// register and result queue before it raises rsp_tvalid.
// Per-output-row partial sums of the first two columns of a column triple
// live in a 1024-entry RAM; the first column overwrites, so no clearing pass.
// Reset: counters to the frame start, sizes back to 300 x 300, pipeline and
// result queue empty.
// Stall: results wait in a 4-deep queue; req_tready drops only when queued
// plus in-flight results could fill it, so ready never depends on rsp_tready.
module gaussian_blur_box_downsample (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sub_red [7:0], sub_green [15:8], sub_blue [23:16]
   input  logic [gbbd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_red [7:0], out_green [15:8], out_blue [23:16], out_col [35:24],
   // out_row [45:36], zero [47:46]
   output logic [gbbd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gbbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gbbd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gbbd_pkg::*;

   // ---------------- configuration and frame position ----------------
   logic [COL_W-1:0] width_m1_ff, width_m1_in;
   logic [ROW_W-1:0] height_m1_ff, height_m1_in;
   warm_type         warm_ff, warm_in;
   phase_type        ph_ff, ph_in;          // phase of next filtered row
   logic [ROW_W-1:0] rr_ff, rr_in;          // output row of next filtered row
   phase_type        col_ph_ff, col_ph_in;
   logic [COL_W-1:0] ocol_ff, ocol_in;

   // ---------------- sample window ----------------
   pixel_type win_ff [4];
   pixel_type win_eff [4];
   pixel_type cur;

   // ---------------- stage 1: taps ----------------
   logic      s1_valid_ff;
   ctl_type   s1_ctl_ff, s1_ctl_in;
   pixel_type s1_tap_ff [5];

   // ---------------- stage 2: filtered values ----------------
   logic      s2_valid_ff;
   ctl_type   s2_ctl_ff;
   pixel_type s2_vmain_ff, s2_va_ff, s2_vb_ff;
   pixel_type vmain_in, va_in, vb_in;

   // per-column running sum for the current output row
   contrib_type colsum_ff, colsum_in;
   contrib_type contrib;
   sum_type     total;
   sum_type     ram_rdata;
   logic        finish;
   logic        ram_wr_en;

   // ---------------- stage 3: block sum ----------------
   logic             s3_valid_ff, s3_valid_in;
   sum_type          s3_total_ff;
   logic [COL_W-1:0] s3_col_ff;
   logic [ROW_W-1:0] s3_row_ff;

   // ---------------- result queue ----------------
   logic [RSP_FIELDS_W-1:0] fifo_ff [FIFO_DEPTH];
   logic [RSP_FIELDS_W-1:0] entry;
   logic [FIFO_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CREDIT_W-1:0]     credit_used;
   logic                    push, pop;

   logic req_fire, csr_fire, csr_hit;
   logic do_filter, last_step, col_end, emit;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign csr_hit   = csr_fire & ((csr_index == CSR_OUT_WIDTH) ||
                                  (csr_index == CSR_OUT_HEIGHT));
   assign req_fire  = req_tvalid & req_tready;
   assign cur       = pixel_type'(req_tdata);

   // Rows above the top repeat row 0: the first sample fills the window.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         win_eff[k] = (warm_ff == WARM_ROW0) ? cur : win_ff[k];
      end
   end

   // Bottom sample of a column (j == 3H-1) lines up with phase 0 of the last row.
   assign do_filter = (warm_ff == WARM_RUN);
   assign last_step = do_filter && (ph_ff == PH_FIRST) && (rr_ff == height_m1_ff);
   assign col_end   = (col_ph_ff == PH_LAST) && (ocol_ff == width_m1_ff);
   assign emit      = do_filter && (col_ph_ff == PH_LAST) &&
                      ((ph_ff == PH_LAST) || last_step);

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      warm_in      = warm_ff;
      ph_in        = ph_ff;
      rr_in        = rr_ff;
      col_ph_in    = col_ph_ff;
      ocol_in      = ocol_ff;
      if (csr_hit) begin
         if (csr_index == CSR_OUT_WIDTH) begin
            width_m1_in = eff_width_m1(csr_data[WIDTH_REG_W-1:0]);
         end else begin
            height_m1_in = eff_height_m1(csr_data[HEIGHT_REG_W-1:0]);
         end
         warm_in   = WARM_ROW0;
         ph_in     = PH_FIRST;
         rr_in     = '0;
         col_ph_in = PH_FIRST;
         ocol_in   = '0;
      end else if (req_fire) begin
         if (last_step) begin
            warm_in = WARM_ROW0;
            ph_in   = PH_FIRST;
            rr_in   = '0;
            if (col_end) begin
               col_ph_in = PH_FIRST;
               ocol_in   = '0;
            end else begin
               col_ph_in = phase_next(col_ph_ff);
               if (col_ph_ff == PH_LAST) begin
                  ocol_in = ocol_ff + COL_W'(1);
               end
            end
         end else if (!do_filter) begin
            warm_in = (warm_ff == WARM_ROW0) ? WARM_ROW1 : WARM_RUN;
         end else begin
            ph_in = phase_next(ph_ff);
            if (ph_ff == PH_LAST) begin
               rr_in = rr_ff + ROW_W'(1);
            end
         end
      end
   end

   always_comb begin
      s1_ctl_in.do_filter = do_filter;
      s1_ctl_in.last_step = last_step;
      s1_ctl_in.emit      = emit;
      s1_ctl_in.row_ph    = ph_ff;
      s1_ctl_in.row       = rr_ff;
      s1_ctl_in.col_ph    = col_ph_ff;
      s1_ctl_in.col       = ocol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= RESET_WIDTH_M1;
         height_m1_ff <= RESET_HEIGHT_M1;
         warm_ff      <= WARM_ROW0;
         ph_ff        <= PH_FIRST;
         rr_ff        <= '0;
         col_ph_ff    <= PH_FIRST;
         ocol_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         warm_ff      <= warm_in;
         ph_ff        <= ph_in;
         rr_ff        <= rr_in;
         col_ph_ff    <= col_ph_in;
         ocol_ff      <= ocol_in;
         s1_valid_ff  <= req_fire;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s3_valid_in;
      end
   end

   // Window shift and stage-1 taps (top to bottom: four stored rows, then new sample)
   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_ff[0]    <= win_eff[1];
         win_ff[1]    <= win_eff[2];
         win_ff[2]    <= win_eff[3];
         win_ff[3]    <= cur;
         s1_tap_ff[0] <= win_eff[0];
         s1_tap_ff[1] <= win_eff[1];
         s1_tap_ff[2] <= win_eff[2];
         s1_tap_ff[3] <= win_eff[3];
         s1_tap_ff[4] <= cur;
         s1_ctl_ff    <= s1_ctl_in;
      end
   end

   // Stage 1: the regular row, plus the two bottom rows clamped to the last sample.
   assign vmain_in = filter_pixel(s1_tap_ff[0], s1_tap_ff[1], s1_tap_ff[2],
                                  s1_tap_ff[3], s1_tap_ff[4]);
   assign va_in    = filter_pixel(s1_tap_ff[1], s1_tap_ff[2], s1_tap_ff[3],
                                  s1_tap_ff[4], s1_tap_ff[4]);
   assign vb_in    = filter_pixel(s1_tap_ff[2], s1_tap_ff[3], s1_tap_ff[4],
                                  s1_tap_ff[4], s1_tap_ff[4]);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_ctl_ff   <= s1_ctl_ff;
         s2_vmain_ff <= vmain_in;
         s2_va_ff    <= va_in;
         s2_vb_ff    <= vb_in;
      end
   end

   // Sums of earlier columns of the triple, read in the cycle before they are used.
   gbbd_ram #(
      .WIDTH (NUM_CHAN * SUM_W),
      .DEPTH (MAX_OUT_HEIGHT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s2_ctl_ff.row),
      .wr_data (total),
      .rd_en   (s1_valid_ff),
      .rd_addr (s1_ctl_ff.row),
      .rd_data (ram_rdata)
   );

   // Stage 2: column sum for this output row, then merge with the RAM.
   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         contrib[k] = CONTRIB_W'(s2_vmain_ff[k]);
         if (s2_ctl_ff.last_step) begin
            contrib[k] = contrib[k] + CONTRIB_W'(s2_va_ff[k]) + CONTRIB_W'(s2_vb_ff[k]);
         end
         colsum_in[k] = (s2_ctl_ff.row_ph == PH_FIRST) ? contrib[k]
                                                       : colsum_ff[k] + contrib[k];
         total[k] = SUM_W'(colsum_in[k]);
         if (s2_ctl_ff.col_ph != PH_FIRST) begin
            total[k] = total[k] + ram_rdata[k];
         end
      end
   end

   assign finish      = s2_valid_ff && s2_ctl_ff.do_filter &&
                        ((s2_ctl_ff.row_ph == PH_LAST) || s2_ctl_ff.last_step);
   assign ram_wr_en   = finish && (s2_ctl_ff.col_ph != PH_LAST);
   assign s3_valid_in = finish && (s2_ctl_ff.col_ph == PH_LAST);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_ctl_ff.do_filter) begin
         colsum_ff <= colsum_in;
      end
      if (s3_valid_in) begin
         s3_total_ff <= total;
         s3_col_ff   <= s2_ctl_ff.col;
         s3_row_ff   <= s2_ctl_ff.row;
      end
   end

   // Stage 3: block average into the result queue.
   assign entry = {OUT_ROW_W'(s3_row_ff), s3_col_ff, avg9(s3_total_ff[2]),
                   avg9(s3_total_ff[1]), avg9(s3_total_ff[0])};

   assign push   = s3_valid_ff;
   assign pop    = rsp_tvalid & rsp_tready;
   assign cnt_in = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = RSP_DATA_W'(fifo_ff[rd_ptr_ff]);

   // Reserve a slot for every result still in the pipeline plus the next request.
   assign credit_used = CREDIT_W'(cnt_ff)
                      + CREDIT_W'(s1_valid_ff & s1_ctl_ff.emit)
                      + CREDIT_W'(s2_valid_ff & s2_ctl_ff.emit)
                      + CREDIT_W'(s3_valid_ff);
   assign req_tready  = (credit_used <= CREDIT_W'(FIFO_DEPTH - 1));

endmodule

### hw/rtl/gbbd_checker.sv
module gbbd_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // Stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // An empty queue fills only from an earlier request that has passed through the pipeline.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 4))
      else $error("result without matching request");

   // Backpressure on requests only while results are waiting.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with empty result queue");

endmodule

bind gaussian_blur_box_downsample gbbd_checker u_gbbd_checker (.*);

### sim/testbench.sv
module testbench;
   import gbbd_pkg::*;

   // Timing and run shape
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int LATENCY_SLACK = 8;           // settle wait for requests still in flight
   localparam int GAP_MAX       = 16;
   localparam int LONG_HOLD     = 300;         // receiver hold-off, longer than the queue can hide
   localparam int RANDOM_ITEMS  = 50;
   localparam int RUN_LIMIT     = 2_000_000;

   // Scaling of the blur kernel and the downsample
   localparam int unsigned SS          = 3;    // supersample factor per axis
   localparam int unsigned KERNEL_EDGE = 492;
   localparam int unsigned KERNEL_NEAR = 958;
   localparam int unsigned KERNEL_MID  = 1201;
   localparam int unsigned Q_SHIFT     = 12;
   localparam int unsigned Q_HALF      = 2048;
   localparam int unsigned CHAN_MAX    = 255;
   localparam int unsigned WIDTH_CAP   = 4096;
   localparam int unsigned HEIGHT_CAP  = 1024;

   // Indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = CSR_INDEX_W'(3);

   // Result bus layout, lowest field first
   localparam int COL_LSB = NUM_CHAN * CHAN_W;
   localparam int ROW_LSB = COL_LSB + COL_W;
   localparam int PAD_LSB = ROW_LSB + OUT_ROW_W;

   typedef struct {
      pixel_type            rgb;
      logic [COL_W-1:0]     col;
      logic [OUT_ROW_W-1:0] row;
   } block_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Mirror of the block: column window, per-row block sums, scan position, sizes
   pixel_type               window [4];
   sum_type                 row_sums [HEIGHT_CAP];
   int unsigned             sub_row    = 0;
   int unsigned             sub_col    = 0;
   logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_REG_W'(300);
   logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_REG_W'(300);

   // Averaged output pixels still owed by the block, oldest first
   block_type pending_blocks [$];

   int unsigned mismatches   = 0;
   int unsigned blocks_seen  = 0;
   int unsigned pixels_sent  = 0;
   int unsigned size_writes  = 0;
   int unsigned input_stalls = 0;

   // Idle control shared by the sender tasks and the result sink
   bit          req_jitter    = 1'b1;
   bit          rsp_jitter    = 1'b1;
   int unsigned sink_hold_req = 0;
   int unsigned hold_left     = 0;
   int unsigned sink_wait     = 0;

   gaussian_blur_box_downsample uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned cols_out();
      if (width_reg == '0) return 1;
      if (32'(width_reg) > WIDTH_CAP) return WIDTH_CAP;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned rows_out();
      if (height_reg == '0) return 1;
      if (32'(height_reg) > HEIGHT_CAP) return HEIGHT_CAP;
      return 32'(height_reg);
   endfunction

   function automatic int unsigned frame_len();
      return SS * SS * cols_out() * rows_out();
   endfunction

   // 5-tap vertical Gaussian on one channel, taps top to bottom
   function automatic chan_type gauss5(input chan_type a, input chan_type b, input chan_type c,
                                       input chan_type d, input chan_type e);
      int unsigned s;
      s = KERNEL_EDGE * (32'(a) + 32'(e)) + KERNEL_NEAR * (32'(b) + 32'(d))
        + KERNEL_MID * 32'(c);
      s = (s + Q_HALF) >> Q_SHIFT;
      return (s > CHAN_MAX) ? chan_type'(CHAN_MAX) : chan_type'(s);
   endfunction

   // Rounded mean of a 3x3 block sum
   function automatic chan_type mean_of_nine(input logic [SUM_W-1:0] s);
      int unsigned m;
      m = (32'(s) + 4) / 9;
      return (m > CHAN_MAX) ? chan_type'(CHAN_MAX) : chan_type'(m);
   endfunction

   // One filtered sub-row joins its block sum; the bottom-right sample closes the block
   task automatic fold_filtered_row(input pixel_type a, input pixel_type b, input pixel_type c,
                                    input pixel_type d, input pixel_type e,
                                    input int unsigned row, input int unsigned col);
      int unsigned orow;
      pixel_type   v;
      block_type   blk;
      orow = row / SS;
      for (int k = 0; k < NUM_CHAN; k++) begin
         v[k] = gauss5(a[k], b[k], c[k], d[k], e[k]);
      end
      // top-left of a block overwrites whatever the previous triple left
      for (int k = 0; k < NUM_CHAN; k++) begin
         if (col % SS == 0 && row % SS == 0) row_sums[orow][k] = SUM_W'(v[k]);
         else row_sums[orow][k] = row_sums[orow][k] + SUM_W'(v[k]);
      end
      if (col % SS == SS - 1 && row % SS == SS - 1) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            blk.rgb[k] = mean_of_nine(row_sums[orow][k]);
         end
         blk.col = COL_W'(col / SS);
         blk.row = OUT_ROW_W'(orow);
         pending_blocks.push_back(blk);
      end
   endtask

   // Advance the mirror by one accepted supersampled pixel
   task automatic track_pixel(input pixel_type cur);
      int unsigned bottom;
      int unsigned right;
      bottom = SS * rows_out() - 1;
      right  = SS * cols_out() - 1;
      // top edge: rows above row 0 repeat row 0
      if (sub_row == 0) begin
         for (int n = 0; n < 4; n++) window[n] = cur;
      end
      if (sub_row >= 2) begin
         fold_filtered_row(window[0], window[1], window[2], window[3], cur, sub_row - 2, sub_col);
      end
      // bottom edge: the last two rows see the last sample repeated
      if (sub_row >= bottom) begin
         fold_filtered_row(window[1], window[2], window[3], cur, cur, bottom - 1, sub_col);
         fold_filtered_row(window[2], window[3], cur, cur, cur, bottom, sub_col);
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = cur;
      if (sub_row >= bottom) begin
         sub_row = 0;
         sub_col = (sub_col >= right) ? 0 : sub_col + 1;
      end else begin
         sub_row = sub_row + 1;
      end
   endtask

   // ---------------------------------------------------------------- result side

   function automatic int unsigned draw_gap(input bit jitter);
      if (!jitter) return 0;
      if ($urandom_range(0, 3) != 0) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_block(input logic [RSP_DATA_W-1:0] d);
      block_type want;
      if (pending_blocks.size() == 0) begin
         $display("%0t: output pixel with none owed, expected nothing, actual %h", $time, d);
         mismatches++;
         return;
      end
      want = pending_blocks.pop_front();
      blocks_seen++;
      compare_field("out_red",   want.rgb[0], d[CHAN_W-1:0]);
      compare_field("out_green", want.rgb[1], d[2*CHAN_W-1:CHAN_W]);
      compare_field("out_blue",  want.rgb[2], d[3*CHAN_W-1:2*CHAN_W]);
      compare_field("out_col",   want.col,    d[ROW_LSB-1:COL_LSB]);
      compare_field("out_row",   want.row,    d[PAD_LSB-1:ROW_LSB]);
      compare_field("pad bits",  '0,         d[RSP_DATA_W-1:PAD_LSB]);
   endtask

   // Sink: checks each accepted result, then draws its own wait; a long hold-off
   // requested by a test is counted down here
   always @(posedge clock) begin : result_sink
      int unsigned gap;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_block(rsp_tdata);
         if (sink_hold_req != 0) begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            gap       = draw_gap(rsp_jitter);
            sink_wait = gap;
            rsp_tready <= (gap == 0);
         end else if (sink_wait != 0) begin
            sink_wait = sink_wait - 1;
            rsp_tready <= (sink_wait == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // Called at a rising edge; returns at the edge that accepted the request.
   // valid stays high into the next request when no gap is drawn.
   task automatic send_pixel(input pixel_type px);
      int unsigned gap;
      gap = draw_gap(req_jitter);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do begin
         @(posedge clock);
         if (!req_tready) input_stalls++;
      end while (!req_tready);
      pixels_sent++;
      track_pixel(px);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      for (int k = 0; k < NUM_CHAN; k++) begin
         case ($urandom_range(0, 5))
            0:       p[k] = '0;
            1:       p[k] = '1;
            default: p[k] = chan_type'($urandom_range(0, CHAN_MAX));
         endcase
      end
      return p;
   endfunction

   task automatic send_run(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // Quiet the input and let every owed pixel come out, plus the pipeline depth,
   // since requests that close no block may still be in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // either size register restarts the frame; spare indexes do nothing
      case (index)
         CSR_OUT_WIDTH: begin
            width_reg = WIDTH_REG_W'(value);
            sub_row   = 0;
            sub_col   = 0;
            size_writes++;
         end
         CSR_OUT_HEIGHT: begin
            height_reg = HEIGHT_REG_W'(value);
            sub_row    = 0;
            sub_col    = 0;
            size_writes++;
         end
         default: ;
      endcase
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      write_reg(CSR_OUT_WIDTH, w);
      write_reg(CSR_OUT_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------- tests

   // 300 x 300 after reset: a few samples deep in column 0 close no block
   task automatic test_reset_size();
      send_run(8);
      settle();
   endtask

   // 1 x 1 frames: saturated, black (top-left overwrite after a bright block),
   // then a pattern that lights the top and bottom rows of each column
   task automatic test_directed_blocks();
      pixel_type p;
      set_size(1, 1);
      repeat (SS * SS) send_pixel('1);
      repeat (SS * SS) send_pixel('0);
      for (int n = 0; n < SS * SS; n++) begin
         p[0] = chan_type'(n * 28);
         p[1] = (n % SS == SS - 1) ? '1 : '0;
         p[2] = (n % SS == 0) ? '1 : '0;
         send_pixel(p);
      end
      settle();
   endtask

   // Zero, small and oversized sizes; frame wrap; restart mid frame; spare indexes
   task automatic test_size_sweep();
      set_size(0, 0);                          // both clamp to 1
      send_run(2 * frame_len());
      set_size(2, 1);
      send_run(frame_len() + 7);               // wraps into a second frame
      write_reg(CSR_SPARE_2, 13'h1FFF);        // no restart, frame carries on
      send_run(frame_len());
      set_size(1, 3);
      send_run(frame_len());
      set_size(3, 2);
      send_run(frame_len() / 2);
      set_size(3, 2);                          // same size, frame starts over
      send_run(frame_len());
      write_reg(CSR_SPARE_3, 0);
      send_run(20);
      set_size(8191, 1);                       // clamps to 4096 columns
      send_run(40);
      set_size(4096, 2);
      send_run(60);
      set_size(1, 2047);                       // clamps to 1024 rows
      send_run(12);
      settle();
   endtask

   // Tallest column: the first samples of a 1 x 1024 frame, with and without idling
   task automatic test_tall_column();
      req_jitter = 1'b0;
      rsp_jitter = 1'b0;
      set_size(1, 1024);
      send_run(16);
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
      send_run(16);
      settle();
   endtask

   // Receiver holds off while requests keep coming, so the queue fills and the
   // block must drop req_tready
   task automatic test_backpressure();
      set_size(1, 1);
      req_jitter    = 1'b0;
      sink_hold_req = LONG_HOLD;
      send_run(8 * SS * SS);
      req_jitter = 1'b1;
      settle();
   endtask

   // Mostly whole frames of random content at random small sizes; some frames
   // cut short and restarted, spare writes, and pauses until all output is in
   task automatic test_random_traffic();
      int unsigned start;
      int unsigned w;
      int unsigned h;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               if (sub_row != 0 || sub_col != 0 || $urandom_range(0, 1) == 0) begin
                  w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                  h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                  set_size(w, h);
               end
               send_run(frame_len() * $urandom_range(1, 2));
            end
            6: begin
               send_run($urandom_range(1, frame_len()));
               set_size($urandom_range(1, 3), $urandom_range(1, 3));
            end
            7: begin
               send_run($urandom_range(1, 20));
               write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                         $urandom_range(0, 8191));
            end
            8: begin
               send_run($urandom_range(1, 20));
               settle();                        // sender waits for every owed pixel
            end
            default: begin
               req_jitter = $urandom_range(0, 2) != 0;
               rsp_jitter = $urandom_range(0, 2) != 0;
               send_run($urandom_range(1, 20));
            end
         endcase
      end
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
      settle();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main_sequence
      for (int n = 0; n < 4; n++) window[n] = '0;
      foreach (row_sums[r]) row_sums[r] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_directed_blocks();
      test_size_sweep();
      test_tall_column();
      test_backpressure();
      test_random_traffic();
      settle();

      $display("%0d pixel requests, %0d output pixels checked, %0d size writes",
               pixels_sent, blocks_seen, size_writes);
      $display("input stalled %0d cycles; sizes from 1x1 up to 4096 columns and 1024 rows",
               input_stalls);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : run_limit
      #RUN_LIMIT;
      $display("%0t: timeout, %0d output pixels still owed", $time, pending_blocks.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
hw/rtl/gbbd_pkg.sv
hw/rtl/gbbd_ram.sv
hw/rtl/gaussian_blur_box_downsample.sv
hw/rtl/gbbd_checker.sv
sim/testbench.sv
